// ----- rtl/stsg_pkg.sv -----
// Shared types, register codes and sine table construction for the tone generator.
package stsg_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_TUNING_WORD     = 3'd0,
    REG_SAMPLE_BITS     = 3'd1,
    REG_CONTAINER_BYTES = 3'd2,
    REG_UNSIGNED_OUTPUT = 3'd3,
    REG_BIG_ENDIAN      = 3'd4
  } cfg_reg_t;

  // Output format, already clamped to legal ranges
  typedef struct packed {
    logic [5:0] bits;   // 8..32
    logic [4:0] shift;  // 32 - bits
    logic [2:0] bps;    // whole bytes in the sample
    logic [2:0] phys;   // 1..4 container bytes
    logic       uns;
    logic       big;
  } fmt_t;

  localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;
  localparam int unsigned TAYLOR_MAX_TERMS = 40;

  // Q62 multiply, keeping bits 125..62 of the full product
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // Divide a series term by (2n+2)(2n+3)
  function automatic logic [63:0] taylor_div(input logic [63:0] a, input int unsigned n);
    logic [63:0] q;
    unique case (n)
      0:  q = a / 64'd6;
      1:  q = a / 64'd20;
      2:  q = a / 64'd42;
      3:  q = a / 64'd72;
      4:  q = a / 64'd110;
      5:  q = a / 64'd156;
      6:  q = a / 64'd210;
      7:  q = a / 64'd272;
      8:  q = a / 64'd342;
      9:  q = a / 64'd420;
      10: q = a / 64'd506;
      11: q = a / 64'd600;
      12: q = a / 64'd702;
      13: q = a / 64'd812;
      14: q = a / 64'd930;
      15: q = a / 64'd1056;
      16: q = a / 64'd1190;
      17: q = a / 64'd1332;
      18: q = a / 64'd1482;
      19: q = a / 64'd1640;
      20: q = a / 64'd1806;
      21: q = a / 64'd1980;
      22: q = a / 64'd2162;
      23: q = a / 64'd2352;
      24: q = a / 64'd2550;
      25: q = a / 64'd2756;
      26: q = a / 64'd2970;
      27: q = a / 64'd3192;
      28: q = a / 64'd3422;
      29: q = a / 64'd3660;
      30: q = a / 64'd3906;
      31: q = a / 64'd4160;
      32: q = a / 64'd4422;
      33: q = a / 64'd4692;
      34: q = a / 64'd4970;
      35: q = a / 64'd5256;
      36: q = a / 64'd5550;
      37: q = a / 64'd5852;
      38: q = a / 64'd6162;
      default: q = a / 64'd6480;
    endcase
    return q;
  endfunction

  // Rounded sin(pi/2 * r / 2^qbits) * (2^31-1), for 0 <= r <= 2^qbits
  function automatic logic [31:0] quarter_sine(input int unsigned r, input int unsigned qbits);
    logic [63:0]  qmask;
    logic [63:0]  x;
    logic [63:0]  x2;
    logic [63:0]  term;
    logic [63:0]  sum;
    logic [127:0] p;
    logic [63:0]  res;
    int unsigned  n;
    qmask = (64'd1 << qbits) - 64'd1;
    x = (HALF_PI_Q62 >> qbits) * 64'(r) + (((HALF_PI_Q62 & qmask) * 64'(r)) >> qbits);
    x2 = mul_q62(x, x);
    term = x;
    sum = x;
    n = 0;
    while (term != 64'd0 && n < TAYLOR_MAX_TERMS) begin
      term = taylor_div(mul_q62(term, x2), n);
      n++;
      if (n[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    p = {64'd0, sum} * 128'h7FFFFFFF;
    p = p + (128'd1 << 61);
    res = p[125:62];
    if (res > 64'h7FFFFFFF) begin
      res = 64'h7FFFFFFF;
    end
    return res[31:0];
  endfunction

  // Full-wave table entry i for a table of 2^abits entries
  function automatic logic [31:0] sine_entry(input int unsigned i, input int unsigned abits);
    int unsigned qbits;
    int unsigned quarter;
    int unsigned quad;
    int unsigned r;
    logic [31:0] mag;
    qbits = abits - 2;
    quarter = 1 << qbits;
    quad = (i >> qbits) & 3;
    r = i & (quarter - 1);
    mag = quarter_sine(((quad & 1) != 0) ? quarter - r : r, qbits);
    return ((quad & 2) != 0) ? (32'd0 - mag) : mag;
  endfunction

endpackage

// ----- rtl/stsg_queue.sv -----
// Small first-in first-out word queue with registered storage.
module stsg_queue import stsg_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  // Store the incoming word
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ----- rtl/stsg_front.sv -----
// Front end: configuration registers, phase accumulator and tick classification.
module stsg_front import stsg_pkg::*; #(
  parameter int TABLE_ADDR_BITS = 10,
  parameter int PHASE_BITS      = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  input  logic                       in_tick,
  input  logic                       q_full,
  output logic                       q_push,
  output logic [TABLE_ADDR_BITS-1:0] q_addr,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [2:0]                 cfg_index,
  input  logic [31:0]                cfg_data,
  output fmt_t                       fmt
);

  logic [31:0]           tuning_word_r;
  logic [5:0]            sample_bits_r;
  logic [2:0]            container_bytes_r;
  logic                  unsigned_output_r;
  logic                  big_endian_r;
  logic [PHASE_BITS-1:0] phase_r;
  logic                  accept;

  assign cfg_ready = 1'b1;
  assign accept    = in_push && !q_full;
  assign q_push    = accept && in_tick;
  assign q_addr    = phase_r[PHASE_BITS-1 -: TABLE_ADDR_BITS];

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tuning_word_r     <= 32'd42852281;
      sample_bits_r     <= 6'd16;
      container_bytes_r <= 3'd2;
      unsigned_output_r <= 1'b0;
      big_endian_r      <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TUNING_WORD:     tuning_word_r     <= cfg_data;
        REG_SAMPLE_BITS:     sample_bits_r     <= cfg_data[5:0];
        REG_CONTAINER_BYTES: container_bytes_r <= cfg_data[2:0];
        REG_UNSIGNED_OUTPUT: unsigned_output_r <= cfg_data[0];
        REG_BIG_ENDIAN:      big_endian_r      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Advance the phase on every word that produces a sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else if (q_push) begin
      phase_r <= phase_r + PHASE_BITS'(tuning_word_r);
    end
  end

  // Clamp format fields
  always_comb begin
    fmt = '0;
    if (sample_bits_r < 6'd8) begin
      fmt.bits = 6'd8;
    end else if (sample_bits_r > 6'd32) begin
      fmt.bits = 6'd32;
    end else begin
      fmt.bits = sample_bits_r;
    end
    if (container_bytes_r == 3'd0) begin
      fmt.phys = 3'd1;
    end else if (container_bytes_r > 3'd4) begin
      fmt.phys = 3'd4;
    end else begin
      fmt.phys = container_bytes_r;
    end
    fmt.shift = 5'(6'd32 - fmt.bits);
    fmt.bps   = fmt.bits[5:3];
    fmt.uns   = unsigned_output_r;
    fmt.big   = big_endian_r;
  end

endmodule

// ----- rtl/stsg_back.sv -----
// Back end: sine table read, sample scaling, byte packing and result queue.
module stsg_back import stsg_pkg::*; #(
  parameter int TABLE_ADDR_BITS = 10
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  fmt_t                       fmt,
  input  logic                       q_empty,
  input  logic [TABLE_ADDR_BITS-1:0] q_addr,
  output logic                       q_pop,
  input  logic                       out_pop,
  output logic                       out_empty,
  output logic [31:0]                out_sample_bytes,
  output logic signed [31:0]         out_sample_value
);

  localparam int TableSize = 1 << TABLE_ADDR_BITS;

  logic [31:0]        sine_rom [TableSize];
  logic               rom_vld_r;
  logic [31:0]        rom_data_r;
  logic               advance;
  logic               rq_full, rq_push;
  logic signed [31:0] val;
  logic [31:0]        res;
  logic [31:0]        packed_w;
  logic [2:0]         nbytes;
  logic [2:0]         src;
  logic [2:0]         pos;
  logic [31:0]        sel;
  logic [63:0]        rq_rdata;

  // Load the fixed sine values
  initial begin
    for (int i = 0; i < TableSize; i++) begin
      sine_rom[i] = sine_entry(i, TABLE_ADDR_BITS);
    end
  end

  assign advance = !rom_vld_r || !rq_full;
  assign q_pop   = !q_empty && advance;
  assign rq_push = rom_vld_r && !rq_full;

  // Track the table read stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_vld_r <= 1'b0;
    end else if (advance) begin
      rom_vld_r <= !q_empty;
    end
  end

  // Read the sine table
  always_ff @(posedge clk) begin
    if (q_pop) begin
      rom_data_r <= sine_rom[q_addr];
    end
  end

  // Scale, flip and pack the sample
  always_comb begin
    val    = $signed(rom_data_r) >>> fmt.shift;
    res    = val;
    if (fmt.uns) begin
      res = res ^ (32'd1 << (fmt.bits - 6'd1));
    end
    nbytes   = (fmt.bps < fmt.phys) ? fmt.bps : fmt.phys;
    packed_w = '0;
    for (int p = 0; p < 4; p++) begin
      pos = 3'(p);
      src = fmt.big ? (fmt.phys - 3'd1 - pos) : pos;
      sel = res >> {src, 3'b000};
      if (pos < fmt.phys && src < nbytes) begin
        packed_w[p*8 +: 8] = sel[7:0];
      end
    end
  end

  // Hold finished results until taken
  stsg_queue #(
    .WIDTH (64),
    .DEPTH (2)
  ) u_result_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (rq_push),
    .wdata ({packed_w, val}),
    .full  (rq_full),
    .pop   (out_pop),
    .rdata (rq_rdata),
    .empty (out_empty)
  );

  assign out_sample_bytes = rq_rdata[63:32];
  assign out_sample_value = $signed(rq_rdata[31:0]);

endmodule

// ----- rtl/sine_tone_sample_generator.sv -----
// Direct digital synthesis sine generator: top level wiring front, queue and back.
// Throughput: one input word per cycle while in_full is low; words without a tick produce no sample.
// A sample reaches the result ports through the address queue write, the sine table read
// register and the result queue write; a full result queue holds it back.
// Reset (rst_n low, synchronous) clears the phase, the queues and loads default registers.
module sine_tone_sample_generator import stsg_pkg::*; #(
  parameter int TABLE_ADDR_BITS = 10,
  parameter int PHASE_BITS      = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic               in_tick,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [31:0]        out_sample_bytes,
  output logic signed [31:0] out_sample_value,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  fmt_t                       fmt;
  logic                       aq_push, aq_pop, aq_empty;
  logic [TABLE_ADDR_BITS-1:0] aq_wdata, aq_rdata;

  stsg_front #(
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
    .PHASE_BITS      (PHASE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_tick   (in_tick),
    .q_full    (in_full),
    .q_push    (aq_push),
    .q_addr    (aq_wdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fmt       (fmt)
  );

  // Table addresses waiting for the back end
  stsg_queue #(
    .WIDTH (TABLE_ADDR_BITS),
    .DEPTH (4)
  ) u_addr_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (aq_push),
    .wdata (aq_wdata),
    .full  (in_full),
    .pop   (aq_pop),
    .rdata (aq_rdata),
    .empty (aq_empty)
  );

  stsg_back #(
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .fmt              (fmt),
    .q_empty          (aq_empty),
    .q_addr           (aq_rdata),
    .q_pop            (aq_pop),
    .out_pop          (out_pop),
    .out_empty        (out_empty),
    .out_sample_bytes (out_sample_bytes),
    .out_sample_value (out_sample_value)
  );

endmodule

// ----- rtl/stsg_checker.sv -----
// Port-level checks for the tone generator, bound to the top level.
module stsg_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_push,
  input logic               in_full,
  input logic               in_tick,
  input logic               out_empty,
  input logic               out_pop,
  input logic [31:0]        out_sample_bytes,
  input logic signed [31:0] out_sample_value
);

  // Reset drains both queues
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  // A waiting result word holds until popped
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_sample_bytes)
      && $stable(out_sample_value))
    else $error("result word changed while stalled");

  // Table magnitude never reaches the most negative code
  a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_sample_value != 32'sh80000000)
    else $error("sample value out of table range");

  // The input side fills only through a push
  a_full_by_push: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_full) |-> $past(in_push) && $past(in_tick))
    else $error("input full without a sample push");

endmodule

bind sine_tone_sample_generator stsg_checker u_stsg_checker (.*);
